@@ rtl/pls_pkg.sv @@
// pls_pkg: request and status codes, cell chain command types.
// Used by every module of positional_list_store. No dependencies.
`default_nettype none

package pls_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned POS_W        = 5;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned REQ_W        = 3;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned REQ_TDATA_W  = 40;   // position + value, padded to bytes

   // request kinds (req_tuser)
   localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
   localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_DUMP     = 3'd6;

   // response status (rsp_tuser)
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_INSERT,
      OP_DELETE,
      OP_ROTATE
   } chain_op_type;

   typedef enum logic [2:0] {
      SEL_HOLD,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_NEW,
      SEL_HEAD
   } cell_sel_type;

   typedef struct packed {
      chain_op_type      op;
      logic [DATA_W-1:0] value;
   } chain_cmd_type;

endpackage : pls_pkg

`default_nettype wire

@@ rtl/pls_cell.sv @@
// pls_cell: one storage cell of the list chain.
// Loads from its left or right neighbour, the head cell or a new word. Uses pls_pkg.
`default_nettype none

module pls_cell (
   input  wire logic                       clock,
   input  wire pls_pkg::cell_sel_type      sel,
   input  wire logic [pls_pkg::DATA_W-1:0] left_value,
   input  wire logic [pls_pkg::DATA_W-1:0] right_value,
   input  wire logic [pls_pkg::DATA_W-1:0] head_value,
   input  wire logic [pls_pkg::DATA_W-1:0] new_value,
   output logic      [pls_pkg::DATA_W-1:0] value
);

   logic [pls_pkg::DATA_W-1:0] value_ff;
   logic [pls_pkg::DATA_W-1:0] value_in;

   always_comb begin
      case (sel)
         pls_pkg::SEL_LEFT:  value_in = left_value;
         pls_pkg::SEL_RIGHT: value_in = right_value;
         pls_pkg::SEL_NEW:   value_in = new_value;
         pls_pkg::SEL_HEAD:  value_in = head_value;
         default:            value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule : pls_cell

`default_nettype wire

@@ rtl/pls_chain.sv @@
// pls_chain: row of pls_cell with per-cell shift selection.
// Insert shifts right of the slot, delete shifts left, rotate moves the head to the tail.
// Uses pls_pkg and pls_cell.
`default_nettype none

module pls_chain #(
   parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF,
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                       clock,
   input  wire pls_pkg::chain_cmd_type     cmd,
   input  wire logic [IW-1:0]              idx,        // slot operated on
   input  wire logic [IW-1:0]              last_idx,   // last occupied slot before a delete or rotate
   output logic      [pls_pkg::DATA_W-1:0] head_value
);

   logic [pls_pkg::DATA_W-1:0] cell_q [CAPACITY];
   pls_pkg::cell_sel_type      sel    [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [IW-1:0] MY_IDX = IW'(i);
      logic [pls_pkg::DATA_W-1:0] left_w;
      logic [pls_pkg::DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_q[i+1];
      end

      always_comb begin
         sel[i] = pls_pkg::SEL_HOLD;
         case (cmd.op)
            pls_pkg::OP_INSERT: begin
               if (MY_IDX > idx)
                  sel[i] = pls_pkg::SEL_LEFT;
               else if (MY_IDX == idx)
                  sel[i] = pls_pkg::SEL_NEW;
            end
            pls_pkg::OP_DELETE: begin
               if (MY_IDX >= idx && MY_IDX < last_idx)
                  sel[i] = pls_pkg::SEL_RIGHT;
            end
            pls_pkg::OP_ROTATE: begin
               if (MY_IDX < last_idx)
                  sel[i] = pls_pkg::SEL_RIGHT;
               else if (MY_IDX == last_idx)
                  sel[i] = pls_pkg::SEL_HEAD;
            end
            default: sel[i] = pls_pkg::SEL_HOLD;
         endcase
      end

      pls_cell u_cell (
         .clock       (clock),
         .sel         (sel[i]),
         .left_value  (left_w),
         .right_value (right_w),
         .head_value  (cell_q[0]),
         .new_value   (cmd.value),
         .value       (cell_q[i])
      );
   end

   assign head_value = cell_q[0];

endmodule : pls_chain

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// positional_list_store: ordered list of up to CAPACITY signed words held in a cell chain.
// Status words are registered and valid in the cycle after the request is accepted.
// Throughput: one insert or delete per cycle, single chain shift, if responses are taken.
// Dump of n elements: ST_DUMP, then n registered words by rotation; no request meanwhile.
// Reset (synchronous): element count and control cleared; cell contents undefined.
// Depends on pls_pkg and pls_chain.
`default_nettype none

module positional_list_store #(
   parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pls_pkg::REQ_TDATA_W-1:0] req_tdata,  // position[4:0], value[36:5]
   input  wire logic [pls_pkg::REQ_W-1:0]       req_tuser,  // req_type[2:0]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [pls_pkg::DATA_W-1:0]      rsp_tdata,  // element[31:0]
   output logic      [pls_pkg::STATUS_W-1:0]    rsp_tuser,  // status[1:0]
   output logic                                 rsp_tlast   // last_of_run
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned PW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  dump_cnt_ff, dump_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pls_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [pls_pkg::DATA_W-1:0]     rsp_elem_ff, rsp_elem_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [pls_pkg::REQ_W-1:0]      req_type;
   logic [pls_pkg::POS_W-1:0]      req_pos;
   logic [pls_pkg::DATA_W-1:0]     req_val;
   logic [PW-1:0]                  pos_ext, cnt_ext;
   logic                           out_free, req_fire, count_up;
   logic                           is_full, is_empty;
   logic [CW-1:0]                  count_m1;

   pls_pkg::chain_cmd_type         cmd;
   logic [IW-1:0]                  idx, last_idx;
   logic [pls_pkg::DATA_W-1:0]     head_value;

   assign req_type = req_tuser;
   assign req_pos  = req_tdata[pls_pkg::POS_W-1:0];
   assign req_val  = req_tdata[pls_pkg::POS_W +: pls_pkg::DATA_W];
   assign pos_ext  = PW'(req_pos);
   assign cnt_ext  = PW'(count_ff);
   assign count_m1 = count_ff - CW'(1);
   assign is_full  = (count_ff == CAP_COUNT);
   assign is_empty = (count_ff == '0);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_cnt_in   = dump_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = pls_pkg::OP_NOP;
      cmd.value     = req_val;
      idx           = '0;
      last_idx      = '0;
      count_up      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // single status word unless a non-empty dump or an unused kind
               rsp_status_in = pls_pkg::STATUS_OK;
               rsp_elem_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               case (req_type)
                  pls_pkg::REQ_INS_HEAD, pls_pkg::REQ_INS_TAIL, pls_pkg::REQ_INS_POS: begin
                     last_idx = IW'(count_ff);
                     if (is_full) begin
                        rsp_status_in = pls_pkg::STATUS_FULL;
                     end else if (req_type == pls_pkg::REQ_INS_POS &&
                                  (pos_ext == '0 || pos_ext > cnt_ext + PW'(1))) begin
                        rsp_status_in = pls_pkg::STATUS_BOUNDS;
                     end else begin
                        cmd.op   = pls_pkg::OP_INSERT;
                        count_in = count_ff + CW'(1);
                        count_up = 1'b1;
                        if (req_type == pls_pkg::REQ_INS_TAIL)
                           idx = IW'(count_ff);
                        else if (req_type == pls_pkg::REQ_INS_POS)
                           idx = IW'(pos_ext - PW'(1));
                        else
                           idx = '0;
                     end
                  end
                  pls_pkg::REQ_DEL_HEAD, pls_pkg::REQ_DEL_TAIL, pls_pkg::REQ_DEL_POS: begin
                     last_idx = IW'(count_m1);
                     if (is_empty) begin
                        rsp_status_in = pls_pkg::STATUS_EMPTY;
                     end else if (req_type == pls_pkg::REQ_DEL_POS &&
                                  (pos_ext == '0 || pos_ext > cnt_ext)) begin
                        rsp_status_in = pls_pkg::STATUS_BOUNDS;
                     end else begin
                        cmd.op   = pls_pkg::OP_DELETE;
                        count_in = count_m1;
                        if (req_type == pls_pkg::REQ_DEL_TAIL)
                           idx = IW'(count_m1);
                        else if (req_type == pls_pkg::REQ_DEL_POS)
                           idx = IW'(pos_ext - PW'(1));
                        else
                           idx = '0;
                     end
                  end
                  pls_pkg::REQ_DUMP: begin
                     if (is_empty) begin
                        rsp_status_in = pls_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        dump_cnt_in  = '0;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     // unused request kind: no word, no change
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            last_idx = IW'(count_m1);
            if (out_free) begin
               // head word goes out, chain rotates; n rotations restore the order
               cmd.op        = pls_pkg::OP_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pls_pkg::STATUS_OK;
               rsp_elem_in   = head_value;
               rsp_last_in   = (dump_cnt_ff == count_m1);
               dump_cnt_in   = dump_cnt_ff + CW'(1);
               if (dump_cnt_ff == count_m1)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   pls_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .idx        (idx),
      .last_idx   (last_idx),
      .head_value (head_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_elem_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("element count above capacity");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> count_ff != '0)
      else $error("dump running on an empty list");

   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !req_tready)
      else $error("request taken during dump");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      count_up |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_dump_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> dump_cnt_ff < count_ff)
      else $error("dump index past the last element");

endmodule : positional_list_store

`default_nettype wire

@@ sim/tb_positional_list_store.sv @@
// tb_positional_list_store: self-checking bench for the positional list store.
// Depends on pls_pkg and the positional_list_store RTL; drives random and directed
// list requests and checks every response word against an in-bench list model.
`timescale 1ns / 100ps

module tb_positional_list_store;

   localparam int          CAP              = pls_pkg::CAPACITY_DEF;
   localparam int          DATA_W           = pls_pkg::DATA_W;
   localparam int          POS_W            = pls_pkg::POS_W;
   localparam int          REQ_W            = pls_pkg::REQ_W;
   localparam int          STATUS_W         = pls_pkg::STATUS_W;
   localparam int          REQ_TDATA_W      = pls_pkg::REQ_TDATA_W;
   localparam int          CLK_PERIOD       = 4;
   localparam int          RESET_CYCLES     = 8;
   localparam int          RANDOM_PER_PHASE = 120;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          CYCLE_LIMIT      = 400000;
   localparam int          PAD_W            = REQ_TDATA_W - DATA_W - POS_W;
   localparam logic [REQ_W-1:0] REQ_UNUSED  = 3'd7;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   element;
      logic                last;
   } rsp_word_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   rsp_tlast;

   req_word_type  pending_reqs[$];
   rsp_word_type  expected_rsps[$];
   req_word_type  next_req;
   rsp_word_type  want_rsp;

   // list as the block should hold it
   logic [DATA_W-1:0] list_cells[CAP];
   int                list_len = 0;

   // element count as seen when the stimulus is built, used to steer positions
   int                gen_len = 0;
   bit                growing = 1'b1;

   int  sender_idle_pct   = 0;
   int  receiver_idle_pct = 0;
   bit  req_taken         = 1'b0;
   int  queued_count      = 0;
   int  taken_count       = 0;
   int  ignored_count     = 0;
   int  rsp_count         = 0;
   int  status_tally[4]   = '{0, 0, 0, 0};
   int  fail_count        = 0;
   int  cycle_count       = 0;

   positional_list_store #(
      .CAPACITY (CAP)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- list model

   task automatic insert_cell(input int idx, input logic [DATA_W-1:0] val);
      for (int i = list_len; i > idx; i--) begin
         list_cells[i] = list_cells[i-1];
      end
      list_cells[idx] = val;
      list_len++;
   endtask

   task automatic remove_cell(input int idx);
      for (int i = idx; i + 1 < list_len; i++) begin
         list_cells[i] = list_cells[i+1];
      end
      list_len--;
   endtask

   // applies one accepted request and queues the response words it must give
   task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
      logic [STATUS_W-1:0] st;
      st = pls_pkg::STATUS_OK;
      case (kind)
         pls_pkg::REQ_INS_HEAD, pls_pkg::REQ_INS_TAIL, pls_pkg::REQ_INS_POS: begin
            // full is checked ahead of the position
            if (list_len >= CAP)
               st = pls_pkg::STATUS_FULL;
            else if (kind == pls_pkg::REQ_INS_HEAD)
               insert_cell(0, val);
            else if (kind == pls_pkg::REQ_INS_TAIL)
               insert_cell(list_len, val);
            else if (pos == 0 || pos > list_len + 1)
               st = pls_pkg::STATUS_BOUNDS;
            else
               insert_cell(pos - 1, val);
         end
         pls_pkg::REQ_DEL_HEAD, pls_pkg::REQ_DEL_TAIL, pls_pkg::REQ_DEL_POS: begin
            if (list_len == 0)
               st = pls_pkg::STATUS_EMPTY;
            else if (kind == pls_pkg::REQ_DEL_HEAD)
               remove_cell(0);
            else if (kind == pls_pkg::REQ_DEL_TAIL)
               remove_cell(list_len - 1);
            else if (pos == 0 || pos > list_len)
               st = pls_pkg::STATUS_BOUNDS;
            else
               remove_cell(pos - 1);
         end
         pls_pkg::REQ_DUMP: begin
            if (list_len == 0) begin
               expected_rsps.push_back({pls_pkg::STATUS_EMPTY, {DATA_W{1'b0}}, 1'b1});
            end else begin
               for (int i = 0; i < list_len; i++) begin
                  expected_rsps.push_back({pls_pkg::STATUS_OK, list_cells[i],
                                           i == list_len - 1});
               end
            end
            return;
         end
         default: begin
            ignored_count++;
            return;
         end
      endcase
      expected_rsps.push_back({st, {DATA_W{1'b0}}, 1'b1});
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
      pending_reqs.push_back({kind, pos, val});
      queued_count++;
      case (kind)
         pls_pkg::REQ_INS_HEAD, pls_pkg::REQ_INS_TAIL: if (gen_len < CAP) gen_len++;
         pls_pkg::REQ_INS_POS: if (gen_len < CAP && pos != 0 && pos <= gen_len + 1) gen_len++;
         pls_pkg::REQ_DEL_HEAD, pls_pkg::REQ_DEL_TAIL: if (gen_len != 0) gen_len--;
         pls_pkg::REQ_DEL_POS: if (gen_len != 0 && pos != 0 && pos <= gen_len) gen_len--;
         default: ;
      endcase
   endtask

   task automatic queue_random();
      int                pick;
      int                top;
      logic [REQ_W-1:0]  kind;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      // swing between filling and draining so that both full and empty are reached
      if (growing && gen_len == CAP && $urandom_range(3) == 0)
         growing = 1'b0;
      else if (!growing && gen_len == 0 && $urandom_range(3) == 0)
         growing = 1'b1;
      else if ($urandom_range(49) == 0)
         growing = !growing;

      pick = $urandom_range(99);
      if (pick < 2) begin
         kind = REQ_UNUSED;
      end else if (pick < 10) begin
         kind = pls_pkg::REQ_DUMP;
      end else if ((pick < 75) == growing) begin
         case ($urandom_range(2))
            0:       kind = pls_pkg::REQ_INS_HEAD;
            1:       kind = pls_pkg::REQ_INS_TAIL;
            default: kind = pls_pkg::REQ_INS_POS;
         endcase
      end else begin
         case ($urandom_range(2))
            0:       kind = pls_pkg::REQ_DEL_HEAD;
            1:       kind = pls_pkg::REQ_DEL_TAIL;
            default: kind = pls_pkg::REQ_DEL_POS;
         endcase
      end

      top = (kind == pls_pkg::REQ_INS_POS) ? gen_len + 1 : gen_len;
      if ((kind == pls_pkg::REQ_INS_POS || kind == pls_pkg::REQ_DEL_POS) && top > 0 &&
          $urandom_range(99) < 85)
         pos = POS_W'($urandom_range(top, 1));
      else
         pos = POS_W'($urandom_range(31));

      case ($urandom_range(39))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7FFF_FFFF;
         2:       val = 32'h0000_0000;
         3:       val = 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase
      queue_request(kind, pos, val);
   endtask

   task automatic queue_directed();
      queue_request(pls_pkg::REQ_DUMP,     5'd0,  32'd0);         // dump of an empty list
      queue_request(pls_pkg::REQ_DEL_HEAD, 5'd0,  32'd0);         // deletes on an empty list
      queue_request(pls_pkg::REQ_DEL_TAIL, 5'd0,  32'd0);
      queue_request(pls_pkg::REQ_DEL_POS,  5'd0,  32'd0);         // empty wins over bad position
      queue_request(pls_pkg::REQ_INS_POS,  5'd0,  32'd1);         // position 0
      queue_request(pls_pkg::REQ_INS_POS,  5'd2,  32'd2);         // beyond count + 1 on empty
      queue_request(pls_pkg::REQ_INS_POS,  5'd1,  32'd5);         // position 1 on empty is head
      queue_request(pls_pkg::REQ_INS_HEAD, 5'd31, 32'h7FFF_FFFF);
      queue_request(pls_pkg::REQ_INS_TAIL, 5'd31, 32'h8000_0000);
      queue_request(pls_pkg::REQ_INS_POS,  5'd2,  32'hFFFF_FFFF);
      queue_request(pls_pkg::REQ_INS_POS,  5'd6,  32'd3);         // count + 2
      queue_request(pls_pkg::REQ_INS_POS,  5'd5,  32'd0);         // count + 1, lands at the tail
      queue_request(pls_pkg::REQ_DUMP,     5'd0,  32'd0);
      queue_request(REQ_UNUSED,            5'd31, 32'hFFFF_FFFF); // dropped without a word
      queue_request(pls_pkg::REQ_DEL_POS,  5'd0,  32'd0);
      queue_request(pls_pkg::REQ_DEL_POS,  5'd6,  32'd0);         // count + 1
      while (gen_len < CAP) begin
         queue_request(pls_pkg::REQ_INS_TAIL, 5'd0, $urandom);
      end
      queue_request(pls_pkg::REQ_INS_HEAD, 5'd0,  32'd9);         // store full
      queue_request(pls_pkg::REQ_INS_POS,  5'd0,  32'd9);         // full wins over bad position
      queue_request(pls_pkg::REQ_DUMP,     5'd0,  32'd0);         // longest dump
      queue_request(pls_pkg::REQ_DEL_POS,  5'd17, 32'd0);
      queue_request(pls_pkg::REQ_DEL_POS,  5'd16, 32'd0);         // last element by position
      queue_request(pls_pkg::REQ_DEL_TAIL, 5'd0,  32'd0);
      queue_request(pls_pkg::REQ_DEL_HEAD, 5'd0,  32'd0);
   endtask

   // sender holds off until every queued request is taken and answered
   task automatic drain();
      while (taken_count != queued_count || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic flag_field(input string field, input longint want, input longint got);
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         // a word on offer stays until taken
         if (!req_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_tuser  <= next_req.kind;
               req_tdata  <= {{PAD_W{1'b0}}, next_req.value, next_req.position};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
      req_taken = 1'b0;
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (!reset) begin
         // request side first, so the model is updated before a word of the same cycle is checked
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            taken_count++;
            apply_request(req_tuser, req_tdata[POS_W-1:0], req_tdata[POS_W+DATA_W-1:POS_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            status_tally[rsp_tuser]++;
            if (expected_rsps.size() == 0) begin
               flag_field("unexpected word, status", -1, rsp_tuser);
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_tuser !== want_rsp.status)
                  flag_field("status", want_rsp.status, rsp_tuser);
               if (rsp_tdata !== want_rsp.element)
                  flag_field("element", $signed(want_rsp.element), $signed(rsp_tdata));
               if (rsp_tlast !== want_rsp.last)
                  flag_field("last_of_run", want_rsp.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycle_count, expected_rsps.size());
         $display("FAIL positional_list_store");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      sender_idle_pct   = 13;
      receiver_idle_pct = 75;
      queue_directed();
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 13;
               receiver_idle_pct = 75;
            end
            1: begin
               sender_idle_pct   = 75;
               receiver_idle_pct = 13;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) queue_random();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests (%0d of the unused kind) and checked %0d response words:",
               taken_count, ignored_count, rsp_count);
      $display("  %0d ok, %0d out of bounds, %0d empty, %0d full; %0d mismatches",
               status_tally[pls_pkg::STATUS_OK], status_tally[pls_pkg::STATUS_BOUNDS],
               status_tally[pls_pkg::STATUS_EMPTY], status_tally[pls_pkg::STATUS_FULL],
               fail_count);
      if (fail_count == 0)
         $display("PASS positional_list_store");
      else
         $display("FAIL positional_list_store");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/pls_chain.sv
rtl/positional_list_store.sv
sim/tb_positional_list_store.sv
